>>> hw/rtl/xor_linear_basis_insert_assert.svh
// Assertion macros for the XOR linear basis block.
// Depends on signals clk and arst_n in the scope of use.
`ifndef XOR_LINEAR_BASIS_INSERT_ASSERT_SVH
`define XOR_LINEAR_BASIS_INSERT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define XLB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xlb assertion failed");

// Check cons in the cycle after ante.
`define XLB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xlb assertion failed");

`endif

>>> hw/rtl/xlb_pkg.sv
// Shared constants for the XOR linear basis block.
// No dependencies; used by the top level and its checker.
package xlb_pkg;

	localparam int VEC_WIDTH_DEF = 64;
	localparam int VEC_BITS      = 64;
	localparam int IDX_BITS      = 6;
	localparam int RANK_BITS     = 7;
	localparam int S_TDATA_W     = 72;
	localparam int S_TUSER_W     = 1;
	localparam int M_TDATA_W     = 80;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

endpackage

>>> hw/rtl/xor_linear_basis_insert.sv
// Insert: an accept step, a scan of all rows from the top down and, if a new pivot is found,
// a fix of the valid rows above the pivot and a store; then an output step. Read: accept,
// row read and output steps. One request at a time; the row memory read port sets the scan pace.
// A finished result waits in the output register until taken, and in DONE while that register is full.
// Reset: asynchronous, clears row valid bits (all rows read as zero), the rank and the output valid.
// Depends on xlb_pkg.
module xor_linear_basis_insert
	import xlb_pkg::*;
#(
	parameter int VEC_WIDTH = VEC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // vector_in[63:0], row_index[69:64], zero pad
	input  logic [S_TUSER_W-1:0] s_tuser,  // req_type[0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // added[0], pivot_bit[6:1], basis_rank[13:7],
	                                       // row_value[77:14], zero pad
);

	localparam int IDX_W = $clog2(VEC_WIDTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VEC_WIDTH - 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RD    = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_FIX   = 6'b001000,
		ST_STORE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [VEC_WIDTH-1:0]   mem_q [VEC_WIDTH];
	logic [VEC_WIDTH-1:0]   valid_q;
	logic [RANK_BITS-1:0]   rank_q;
	logic [VEC_WIDTH-1:0]   v_q;
	logic [VEC_WIDTH-1:0]   rd_data_q;
	logic [VEC_WIDTH-1:0]   res_row_q;
	logic                   res_added_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       pivot_q;
	logic                   found_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	logic                   s_accept;
	logic                   out_free;
	logic                   req_type;
	logic [IDX_BITS-1:0]    row_index;
	logic                   bit_set;
	logic                   hit;
	logic                   new_piv;
	logic                   found_next;
	logic [IDX_W-1:0]       piv_next;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VEC_WIDTH-1:0]   wr_data;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid & s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign req_type  = s_tuser[0];
	assign row_index = s_tdata[VEC_BITS+IDX_BITS-1:VEC_BITS];
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign bit_set    = v_q[cnt_q];
	assign hit        = bit_set & valid_q[cnt_q];
	assign new_piv    = bit_set & !valid_q[cnt_q] & !found_q;
	assign piv_next   = new_piv ? cnt_q : pivot_q;
	assign found_next = found_q | new_piv;

	always_comb begin
		unique case (state_q)
			ST_IDLE:  rd_addr = (req_type == REQ_READ) ? row_index[IDX_W-1:0] : LAST_IDX;
			ST_SCAN:  rd_addr = (cnt_q == '0) ? piv_next + IDX_W'(1) : cnt_q - IDX_W'(1);
			ST_FIX:   rd_addr = cnt_q + IDX_W'(1);
			default:  rd_addr = cnt_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = rd_data_q ^ v_q;
		unique case (state_q)
			ST_FIX: begin
				wr_en = valid_q[cnt_q] & rd_data_q[pivot_q];
			end
			ST_STORE: begin
				wr_en   = 1'b1;
				wr_addr = pivot_q;
				wr_data = v_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			rank_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= (req_type == REQ_READ) ? ST_RD : ST_SCAN;
					end
				end
				ST_RD: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (cnt_q == '0) begin
						if (!found_next) begin
							state_q <= ST_DONE;
						end else if (piv_next == LAST_IDX) begin
							state_q <= ST_STORE;
						end else begin
							state_q <= ST_FIX;
						end
					end
				end
				ST_FIX: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					valid_q[pivot_q] <= 1'b1;
					rank_q           <= rank_q + RANK_BITS'(1);
					state_q          <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					v_q         <= s_tdata[VEC_WIDTH-1:0];
					pivot_q     <= '0;
					res_row_q   <= '0;
					res_added_q <= 1'b0;
					if (req_type == REQ_READ) begin
						cnt_q   <= row_index[IDX_W-1:0];
						found_q <= ({1'b0, row_index} < RANK_BITS'(VEC_WIDTH));
					end else begin
						cnt_q   <= LAST_IDX;
						found_q <= 1'b0;
					end
				end
			end
			ST_RD: begin
				res_row_q <= (found_q && valid_q[cnt_q]) ? rd_data_q : '0;
			end
			ST_SCAN: begin
				if (hit) begin
					v_q <= v_q ^ rd_data_q;
				end
				pivot_q <= piv_next;
				found_q <= found_next;
				cnt_q   <= (cnt_q == '0) ? piv_next + IDX_W'(1) : cnt_q - IDX_W'(1);
			end
			ST_FIX: begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			ST_STORE: begin
				res_added_q <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, VEC_BITS'(res_row_q), rank_q,
						res_added_q ? IDX_BITS'(pivot_q) : IDX_BITS'(0), res_added_q};
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

>>> hw/rtl/xlb_checker.sv
// Port-level checker for the XOR linear basis block, bound to the top level.
// Depends on xlb_pkg and xor_linear_basis_insert_assert.svh.
`include "xor_linear_basis_insert_assert.svh"
module xlb_checker
	import xlb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	`XLB_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
	`XLB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`XLB_ASSERT_SAME(a_rank_bound, m_tvalid, m_tdata[13:7] <= 7'd64)
	`XLB_ASSERT_SAME(a_pivot_zero, m_tvalid && !m_tdata[0], m_tdata[6:1] == 6'd0)
	`XLB_ASSERT_SAME(a_insert_no_row, m_tvalid && m_tdata[0], m_tdata[77:14] == 64'd0)

endmodule

bind xor_linear_basis_insert xlb_checker u_xlb_checker (.*);
